// File: rtl/core/ttm_pkg.sv
// Package holding the shared constants, codes and control structs of the TTM reply parser.
`default_nettype none

package ttm_pkg;

  localparam int BODY_DEPTH = 32;
  localparam int MAC_CHARS  = 12;
  localparam int ADDR_W     = $clog2(BODY_DEPTH);
  localparam int IDX_W      = 4;

  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic KIND_OK  = 1'b0;
  localparam logic KIND_MAC = 1'b1;

  typedef struct packed {
    logic cnt_clear;
    logic wr_en;
    logic idx_clear;
    logic idx_inc;
    logic load_ok;
    logic load_mac;
  } ttm_cmd_t;

  typedef struct packed {
    logic is_t;
    logic is_m;
    logic is_colon;
    logic is_nul;
    logic count_last;
    logic ok_match;
    logic mac_match;
    logic idx_last;
    logic out_free;
  } ttm_status_t;

endpackage

`default_nettype wire

// File: rtl/core/ttm_in_if.sv
// Interface carrying one received byte word with its pass-through flag.
`default_nettype none

interface ttm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       pass_through;

  modport source (output valid, output rx_byte, output pass_through, input ready);
  modport sink (input valid, input rx_byte, input pass_through, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ttm_out_if.sv
// Interface carrying one parser event word.
`default_nettype none

interface ttm_out_if;
  logic       valid;
  logic       ready;
  logic       event_kind;
  logic [7:0] mac_char;
  logic [3:0] char_index;
  logic       last_of_run;

  modport source (output valid, output event_kind, output mac_char, output char_index,
                  output last_of_run, input ready);
  modport sink (input valid, input event_kind, input mac_char, input char_index,
                input last_of_run, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ttm_ctrl.sv
// Controller state machine: prefix hunt, body gathering and MAC character sequencing.
`default_nettype none

module ttm_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_pass,
  output logic                      in_ready,
  input  wire ttm_pkg::ttm_status_t status,
  output ttm_pkg::ttm_cmd_t         cmd
);
  import ttm_pkg::*;

  typedef enum logic [2:0] {
    S_HUNT, S_T, S_TT, S_TTM, S_BODY, S_MRD, S_MWR
  } state_t;

  state_t state, state_next;
  logic   take;

  always_comb begin
    in_ready = ((state == S_HUNT) || (state == S_T) || (state == S_TT) ||
                (state == S_TTM) || (state == S_BODY)) && status.out_free;
    take       = in_valid && in_ready && !in_pass;
    cmd        = '0;
    state_next = state;
    case (state)
      S_HUNT: begin
        if (take && status.is_t) state_next = S_T;
      end
      S_T: begin
        if (take) state_next = status.is_t ? S_TT : S_HUNT;
      end
      S_TT: begin
        if (take) state_next = status.is_m ? S_TTM : S_HUNT;
      end
      S_TTM: begin
        if (take) begin
          cmd.cnt_clear = 1'b1;
          state_next    = status.is_colon ? S_BODY : S_HUNT;
        end
      end
      S_BODY: begin
        if (take) begin
          if (status.is_nul) begin
            cmd.cnt_clear = 1'b1;
            state_next    = S_HUNT;
            if (status.ok_match) begin
              cmd.load_ok = 1'b1;
            end else if (status.mac_match) begin
              cmd.idx_clear = 1'b1;
              state_next    = S_MRD;
            end
          end else begin
            cmd.wr_en = 1'b1;
            // A body that reaches the buffer depth is dropped.
            if (status.count_last) begin
              cmd.cnt_clear = 1'b1;
              state_next    = S_HUNT;
            end
          end
        end
      end
      S_MRD: begin
        state_next = S_MWR;
      end
      S_MWR: begin
        if (status.out_free) begin
          cmd.load_mac = 1'b1;
          if (status.idx_last) begin
            state_next = S_HUNT;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_MRD;
          end
        end
      end
      default: begin
        state_next = S_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HUNT;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ttm_dpath.sv
// Datapath: body memory, byte count, header bytes, MAC index and output register.
`default_nettype none

module ttm_dpath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [7:0]           rx_byte,
  input  wire ttm_pkg::ttm_cmd_t    cmd,
  output ttm_pkg::ttm_status_t      status,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic                      out_kind,
  output logic [7:0]                out_char,
  output logic [ttm_pkg::IDX_W-1:0] out_index,
  output logic                      out_last
);
  import ttm_pkg::*;

  logic [7:0]        mem [BODY_DEPTH];
  logic [7:0]        rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] count;
  logic [7:0]        head0, head1, head2;
  logic [IDX_W-1:0]  idx;

  assign rd_addr = ADDR_W'(3) + ADDR_W'(idx);

  always_comb begin
    status.is_t       = (rx_byte == CH_T);
    status.is_m       = (rx_byte == CH_M);
    status.is_colon   = (rx_byte == CH_COLON);
    status.is_nul     = (rx_byte == CH_NUL);
    status.count_last = (count == ADDR_W'(BODY_DEPTH - 1));
    status.ok_match   = (count >= ADDR_W'(2)) && (head0 == CH_O) && (head1 == CH_K);
    status.mac_match  = (count >= ADDR_W'(MAC_CHARS + 3)) && (head0 == CH_M) &&
                        (head1 == CH_A) && (head2 == CH_C);
    status.idx_last   = (idx == IDX_W'(MAC_CHARS - 1));
    status.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[count] <= rx_byte;
    end
    rd_data <= mem[rd_addr];
  end

  // The first three body bytes are kept aside so the reply type is known at the NUL.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      if (count == ADDR_W'(0)) head0 <= rx_byte;
      if (count == ADDR_W'(1)) head1 <= rx_byte;
      if (count == ADDR_W'(2)) head2 <= rx_byte;
    end
    if (cmd.idx_clear) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IDX_W'(1);
    end
    if (cmd.load_ok) begin
      out_kind  <= KIND_OK;
      out_char  <= '0;
      out_index <= '0;
      out_last  <= 1'b1;
    end else if (cmd.load_mac) begin
      out_kind  <= KIND_MAC;
      out_char  <= rd_data;
      out_index <= idx;
      out_last  <= status.idx_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.cnt_clear) begin
        count <= '0;
      end else if (cmd.wr_en) begin
        count <= count + ADDR_W'(1);
      end
      if (cmd.load_ok || cmd.load_mac) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ttm_response_parser.sv
// Top level of the TTM reply parser: controller, datapath and assertions.
`default_nettype none

// Takes one received byte word per cycle while hunting for "TTM:" and gathering the
// body, while no output word is pending; bytes with pass_through set are swallowed
// without effect. An "OK" body yields one event when its NUL is accepted. A "MAC"
// body yields twelve character words, each read from the body memory through a
// registered read port before it is loaded into the output register; no byte is
// accepted during that run. A pending output word blocks new input only until it is
// taken. Bodies of 32 bytes are dropped.
module ttm_response_parser (
  input  wire logic  clk,
  input  wire logic  rst,
  ttm_in_if.sink     in_ch,
  ttm_out_if.source  out_ch
);
  import ttm_pkg::*;

  ttm_cmd_t    cmd;
  ttm_status_t status;

  ttm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_pass  (in_ch.pass_through),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  ttm_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .rx_byte   (in_ch.rx_byte),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_kind  (out_ch.event_kind),
    .out_char  (out_ch.mac_char),
    .out_index (out_ch.char_index),
    .out_last  (out_ch.last_of_run)
  );

  // No byte may be taken in the middle of a MAC character run.
  a_no_input_mid_run: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && out_ch.event_kind == KIND_MAC && !out_ch.last_of_run)
    |-> !in_ch.ready)
    else $error("input accepted during MAC run");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.char_index <= IDX_W'(MAC_CHARS - 1)))
    else $error("MAC character index out of range");

  a_ok_shape: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.event_kind == KIND_OK) |->
    (out_ch.mac_char == 8'h00 && out_ch.char_index == '0 && out_ch.last_of_run))
    else $error("malformed OK event");

  a_last_has_top_index: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.event_kind == KIND_MAC && out_ch.last_of_run) |->
    (out_ch.char_index == IDX_W'(MAC_CHARS - 1)))
    else $error("MAC run ended at wrong index");

endmodule

`default_nettype wire
